@@ hdl/rotate_vector_to_mean_direction_macros.svh @@
// ----------------------------------------------------------------------------
// rotate_vector_to_mean_direction assertion macros
// shorthand for the concurrent checks used by the checker
// ----------------------------------------------------------------------------
`ifndef ROTATE_VECTOR_TO_MEAN_DIRECTION_MACROS_SVH
`define ROTATE_VECTOR_TO_MEAN_DIRECTION_MACROS_SVH

// check that is suspended while reset is asserted
`define RVMD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rvmd assertion failed");

// check that also holds during reset
`define RVMD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rvmd assertion failed");

`endif

@@ hdl/rvmd_pkg.sv @@
// ----------------------------------------------------------------------------
// rvmd_pkg
// shared types, constants and helpers of the mean direction rotator
// ----------------------------------------------------------------------------
package rvmd_pkg;

	localparam int FW    = 18;
	localparam int NSQ   = 17;
	localparam int NDIV  = 17;
	localparam int STG_PREP  = 0;
	localparam int STG_SQFIX = STG_PREP + NSQ + 1;
	localparam int STG_DPREP = STG_SQFIX + 1;
	localparam int STG_QFIX  = STG_DPREP + NDIV + 1;
	localparam int STG_MAC   = STG_QFIX + 1;
	localparam int NMAC  = 4;
	localparam int NSTG  = STG_MAC + NMAC;

	typedef logic signed [FW-1:0] fld_t;

	typedef struct packed {
		fld_t wx;
		fld_t wy;
		fld_t wz;
		fld_t mx;
		fld_t my;
		fld_t mz;
		logic pole;
	} pld_t;

	// square root iteration state
	typedef struct packed {
		pld_t        p;
		logic [33:0] rem;
		logic [33:0] root;
		logic [33:0] bitv;
	} sq_t;

	typedef struct packed {
		pld_t        p;
		logic [16:0] s;
	} sqo_t;

	// one restoring division lane
	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [16:0] rem;
		logic [16:0] low;
		logic [16:0] q;
	} dv_t;

	typedef struct packed {
		pld_t        p;
		logic [16:0] s;
		dv_t         cx;
		dv_t         cy;
	} dvs_t;

	typedef struct packed {
		pld_t        p;
		logic [16:0] s;
		fld_t        cp;
		fld_t        sp;
	} mac_in_t;

	typedef struct packed {
		fld_t ux;
		fld_t uy;
		fld_t uz;
	} res_t;

	localparam logic signed [20:0] ONE21 = 21'sd65536;

	function automatic fld_t clamp_one(input logic signed [20:0] v);
		fld_t r;
		if (v > ONE21) begin
			r = 18'sd65536;
		end else if (v < -ONE21) begin
			r = -18'sd65536;
		end else begin
			r = v[FW-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/rvmd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rvmd_sqrt_cell
// one digit step of the integer square root, registered
// ----------------------------------------------------------------------------
module rvmd_sqrt_cell import rvmd_pkg::*; (
	input  logic clk,
	input  logic en,
	input  sq_t  din,
	output sq_t  dout
);

	sq_t         dout_q;
	logic [33:0] trial;

	assign trial = din.root + din.bitv;

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q.p    <= din.p;
			dout_q.bitv <= din.bitv >> 2;
			if (din.rem >= trial) begin
				dout_q.rem  <= din.rem - trial;
				dout_q.root <= (din.root >> 1) + din.bitv;
			end else begin
				dout_q.rem  <= din.rem;
				dout_q.root <= din.root >> 1;
			end
		end
	end

	assign dout = dout_q;

endmodule

@@ hdl/rvmd_div_cell.sv @@
// ----------------------------------------------------------------------------
// rvmd_div_cell
// one quotient bit of both restoring dividers, registered
// ----------------------------------------------------------------------------
module rvmd_div_cell import rvmd_pkg::*; (
	input  logic clk,
	input  logic en,
	input  dvs_t din,
	output dvs_t dout
);

	dvs_t dout_q;

	function automatic dv_t step(input dv_t d, input logic [16:0] s);
		dv_t         r;
		logic [17:0] t;
		t = {d.rem, d.low[16]};
		r = d;
		r.low = {d.low[15:0], 1'b0};
		if (t >= {1'b0, s}) begin
			r.rem = 17'(t - {1'b0, s});
			r.q   = {d.q[15:0], 1'b1};
		end else begin
			r.rem = t[16:0];
			r.q   = {d.q[15:0], 1'b0};
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q.p  <= din.p;
			dout_q.s  <= din.s;
			dout_q.cx <= step(din.cx, din.s);
			dout_q.cy <= step(din.cy, din.s);
		end
	end

	assign dout = dout_q;

endmodule

@@ hdl/rvmd_mac.sv @@
// ----------------------------------------------------------------------------
// rvmd_mac
// rotation matrix products, sums, rounding and saturation in four stages
// ----------------------------------------------------------------------------
module rvmd_mac import rvmd_pkg::*; (
	input  logic          clk,
	input  logic [NMAC-1:0] en,
	input  mac_in_t       din,
	output res_t          dout
);

	typedef struct packed {
		fld_t wx;
		fld_t wy;
		fld_t wz;
		logic mzneg;
		logic pole;
	} side_t;

	side_t                sd_s1, sd_s2, sd_s3;
	fld_t                 cp_s1, sp_s1;
	logic signed [33:0]   a1_s1, a2_s1, a3_s1, a4_s1;
	logic signed [35:0]   e1_s1, e2_s1;
	logic signed [51:0]   p1_s2, p3_s2, p4_s2, p6_s2;
	logic signed [35:0]   p2_s2, p5_s2, uzs_s2;
	logic signed [52:0]   sx_s3, sy_s3;
	logic signed [35:0]   sz_s3;
	res_t                 res_s4;

	logic signed [17:0]   s_sg;
	logic signed [35:0]   m1, m2, m3, m4;
	logic signed [53:0]   rx, ry;
	logic signed [36:0]   rz;

	assign s_sg = $signed({1'b0, din.s});
	assign m1 = din.p.mz * din.cp;
	assign m2 = din.p.mz * din.sp;
	assign m3 = s_sg * din.cp;
	assign m4 = s_sg * din.sp;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sd_s1 <= '{din.p.wx, din.p.wy, din.p.wz, din.p.mz[FW-1], din.p.pole};
			cp_s1 <= din.cp;
			sp_s1 <= din.sp;
			a1_s1 <= m1[33:0];
			a2_s1 <= m2[33:0];
			a3_s1 <= m3[33:0];
			a4_s1 <= m4[33:0];
			e1_s1 <= s_sg * din.p.wx;
			e2_s1 <= din.p.mz * din.p.wz;
		end
		if (en[1]) begin
			sd_s2  <= sd_s1;
			p1_s2  <= a1_s1 * sd_s1.wx;
			p2_s2  <= sp_s1 * sd_s1.wy;
			p3_s2  <= a3_s1 * sd_s1.wz;
			p4_s2  <= a2_s1 * sd_s1.wx;
			p5_s2  <= cp_s1 * sd_s1.wy;
			p6_s2  <= a4_s1 * sd_s1.wz;
			uzs_s2 <= e2_s1 - e1_s1;
		end
		if (en[2]) begin
			sd_s3 <= sd_s2;
			sx_s3 <= 53'(p1_s2) - (53'(p2_s2) <<< 16) + 53'(p3_s2);
			sy_s3 <= 53'(p4_s2) + (53'(p5_s2) <<< 16) + 53'(p6_s2);
			sz_s3 <= uzs_s2;
		end
		if (en[3]) begin
			if (sd_s3.pole) begin
				if (sd_s3.mzneg) begin
					res_s4.ux <= clamp_one(-21'(sd_s3.wx));
					res_s4.uy <= clamp_one(-21'(sd_s3.wy));
					res_s4.uz <= clamp_one(-21'(sd_s3.wz));
				end else begin
					res_s4.ux <= clamp_one(21'(sd_s3.wx));
					res_s4.uy <= clamp_one(21'(sd_s3.wy));
					res_s4.uz <= clamp_one(21'(sd_s3.wz));
				end
			end else begin
				res_s4.ux <= clamp_one(rx[52:32]);
				res_s4.uy <= clamp_one(ry[52:32]);
				res_s4.uz <= clamp_one(rz[36:16]);
			end
		end
	end

	// round half up at the q.16 point
	assign rx = 54'(sx_s3) + 54'sd2147483648;
	assign ry = 54'(sy_s3) + 54'sd2147483648;
	assign rz = 37'(sz_s3) + 37'sd32768;

	assign dout = res_s4;

endmodule

@@ hdl/rotate_vector_to_mean_direction.sv @@
// ----------------------------------------------------------------------------
// rotate_vector_to_mean_direction
// rotates w so that the z axis lands on the unit direction mu
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the output is not stalled, carried by the chain
//   of 17 square root and 17 divider cells, each passing data on every cycle it is not held
// stalls: each stage holds while the next one is full and blocked
// reset: arst_n clears every stage valid bit, payload registers are not reset
module rotate_vector_to_mean_direction import rvmd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // w_x, w_y, w_z, mu_x, mu_y, mu_z, zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata   // u_x, u_y, u_z, zero pad
);

	logic [NSTG-1:0] v_q;
	logic [NSTG:0]   rdy;

	pld_t               in_p;
	logic signed [35:0] mz2;
	logic               pole;

	sq_t     sq [0:NSQ];
	sqo_t    sqo_q;
	dvs_t    dv [0:NDIV];
	dvs_t    dprep_q;
	mac_in_t qfix_q;
	res_t    res;

	logic [17:0] amx, amy;
	logic [33:0] nx, ny;
	logic [16:0] magx, magy;

	always_comb begin
		rdy[NSTG] = m_axis_tready;
		for (int i = 0; i < NSTG; i++) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= s_axis_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (rdy[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign s_axis_tready = rdy[0];
	assign m_axis_tvalid = v_q[NSTG-1];

	// input split and pole test
	assign in_p.wx = s_axis_tdata[17:0];
	assign in_p.wy = s_axis_tdata[35:18];
	assign in_p.wz = s_axis_tdata[53:36];
	assign in_p.mx = s_axis_tdata[71:54];
	assign in_p.my = s_axis_tdata[89:72];
	assign in_p.mz = s_axis_tdata[107:90];
	assign mz2  = in_p.mz * in_p.mz;
	assign pole = mz2 >= 36'sd4294967296;

	always_ff @(posedge clk) begin
		if (rdy[STG_PREP]) begin
			sq[0].p      <= '{in_p.wx, in_p.wy, in_p.wz, in_p.mx, in_p.my, in_p.mz, pole};
			sq[0].rem    <= pole ? 34'd0 : 34'(36'sd4294967296 - mz2);
			sq[0].root   <= '0;
			sq[0].bitv   <= 34'd1 << 32;
		end
	end

	for (genvar j = 0; j < NSQ; j++) begin : g_sq
		rvmd_sqrt_cell u_cell (
			.clk  (clk),
			.en   (rdy[STG_PREP+1+j]),
			.din  (sq[j]),
			.dout (sq[j+1])
		);
	end

	// round the root to nearest
	always_ff @(posedge clk) begin
		if (rdy[STG_SQFIX]) begin
			sqo_q.p <= sq[NSQ].p;
			sqo_q.s <= 17'(sq[NSQ].root + 34'(sq[NSQ].rem > sq[NSQ].root));
		end
	end

	// dividend |m| * 2^16 + s/2, quotient overflow flagged up front
	assign amx = sqo_q.p.mx[FW-1] ? 18'(-sqo_q.p.mx) : 18'(sqo_q.p.mx);
	assign amy = sqo_q.p.my[FW-1] ? 18'(-sqo_q.p.my) : 18'(sqo_q.p.my);
	assign nx  = {amx, 16'd0} + 34'(sqo_q.s >> 1);
	assign ny  = {amy, 16'd0} + 34'(sqo_q.s >> 1);

	always_ff @(posedge clk) begin
		if (rdy[STG_DPREP]) begin
			dprep_q.p      <= sqo_q.p;
			dprep_q.s      <= sqo_q.s;
			dprep_q.cx.neg <= sqo_q.p.mx[FW-1];
			dprep_q.cx.ovf <= nx[33:17] >= sqo_q.s;
			dprep_q.cx.rem <= nx[33:17];
			dprep_q.cx.low <= nx[16:0];
			dprep_q.cx.q   <= '0;
			dprep_q.cy.neg <= sqo_q.p.my[FW-1];
			dprep_q.cy.ovf <= ny[33:17] >= sqo_q.s;
			dprep_q.cy.rem <= ny[33:17];
			dprep_q.cy.low <= ny[16:0];
			dprep_q.cy.q   <= '0;
		end
	end

	assign dv[0] = dprep_q;

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		rvmd_div_cell u_cell (
			.clk  (clk),
			.en   (rdy[STG_DPREP+1+j]),
			.din  (dv[j]),
			.dout (dv[j+1])
		);
	end

	// saturate the quotients to one and restore the sign
	assign magx = (dv[NDIV].cx.ovf || dv[NDIV].cx.q > 17'd65536) ? 17'd65536 : dv[NDIV].cx.q;
	assign magy = (dv[NDIV].cy.ovf || dv[NDIV].cy.q > 17'd65536) ? 17'd65536 : dv[NDIV].cy.q;

	always_ff @(posedge clk) begin
		if (rdy[STG_QFIX]) begin
			qfix_q.p  <= dv[NDIV].p;
			qfix_q.s  <= dv[NDIV].s;
			qfix_q.cp <= dv[NDIV].cx.neg ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
			qfix_q.sp <= dv[NDIV].cy.neg ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
		end
	end

	rvmd_mac u_mac (
		.clk  (clk),
		.en   (rdy[NSTG-1:STG_MAC]),
		.din  (qfix_q),
		.dout (res)
	);

	assign m_axis_tdata = {2'b00, res.uz, res.uy, res.ux};

endmodule

@@ hdl/rvmd_checker.sv @@
// ----------------------------------------------------------------------------
// rvmd_checker
// port level checks of the mean direction rotator, bound to the top level
// ----------------------------------------------------------------------------
`include "rotate_vector_to_mean_direction_macros.svh"

module rvmd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [55:0]  m_axis_tdata   // u_x, u_y, u_z, zero pad
);

	logic signed [17:0] ux, uy, uz;
	logic               in_range;

	assign ux = m_axis_tdata[17:0];
	assign uy = m_axis_tdata[35:18];
	assign uz = m_axis_tdata[53:36];
	assign in_range = (ux >= -18'sd65536) && (ux <= 18'sd65536) &&
		(uy >= -18'sd65536) && (uy <= 18'sd65536) &&
		(uz >= -18'sd65536) && (uz <= 18'sd65536) && (m_axis_tdata[55:54] == 2'b00);

	// a held result keeps its data
	`RVMD_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	// results are always saturated
	`RVMD_ASSERT(a_range, clk, arst_n, m_axis_tvalid |-> in_range)
	// an empty or draining output never blocks the input
	`RVMD_ASSERT(a_flow, clk, arst_n, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
	// nothing is presented while in reset
	`RVMD_ASSERT_ALWAYS(a_reset, clk, !arst_n |-> !m_axis_tvalid)

endmodule

bind rotate_vector_to_mean_direction rvmd_checker u_rvmd_checker (.*);
